/* rtl/dsmc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes, constants and coil tables for the dual stepper move controller.
// No dependencies; imported by every rtl module of the block.
package dsmc_pkg;

  localparam int unsigned PhaseCountDef    = 8;
  localparam int unsigned StepCountBitsDef = 16;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [1:0] ModeStart = 2'd0;
  localparam logic [1:0] ModeTickL = 2'd1;
  localparam logic [1:0] ModeTickR = 2'd2;

  localparam logic [2:0] MvFwd     = 3'd0;
  localparam logic [2:0] MvHalf    = 3'd1;
  localparam logic [2:0] MvLeft    = 3'd2;
  localparam logic [2:0] MvRight   = 3'd3;
  localparam logic [2:0] MvBack    = 3'd4;
  localparam logic [2:0] MvQuarter = 3'd5;
  localparam logic [2:0] MvTurnL   = 3'd6;
  localparam logic [2:0] MvTurnR   = 3'd7;

  localparam logic [2:0] RegStepsBlock   = 3'd0;
  localparam logic [2:0] RegStepsQuarter = 3'd1;
  localparam logic [2:0] RegBaseReload   = 3'd2;
  localparam logic [2:0] RegWallLeft     = 3'd3;
  localparam logic [2:0] RegWallRight    = 3'd4;
  localparam logic [2:0] RegCenterLeft   = 3'd5;
  localparam logic [2:0] RegCenterRight  = 3'd6;
  localparam logic [2:0] RegFrontStop    = 3'd7;

  localparam logic [15:0] BaseReloadRst = 16'd65380;
  localparam logic [9:0]  FrontStopRst  = 10'd1023;
  localparam logic [15:0] ReloadTurn    = 16'd65350;
  localparam logic [15:0] ReloadBack    = 16'd65300;
  localparam logic [15:0] CenterStep    = 16'd5;
  localparam logic [15:0] CenterSpan    = 16'd35;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] move;
    logic [9:0] left_reading;
    logic [9:0] right_reading;
    logic [9:0] front_reading;
  } dsmc_in_t;

  typedef struct packed {
    logic [3:0]  left_coils;
    logic [3:0]  right_coils;
    logic [15:0] left_timer_reload;
    logic [15:0] right_timer_reload;
    logic        moving;
    logic        move_done;
    logic        correcting;
  } dsmc_out_t;

  typedef struct packed {
    logic [15:0] steps_per_block;
    logic [14:0] steps_per_quarter_turn;
    logic [15:0] base_reload;
    logic [9:0]  wall_limit_left;
    logic [9:0]  wall_limit_right;
    logic [9:0]  center_limit_left;
    logic [9:0]  center_limit_right;
    logic [9:0]  front_stop_limit;
  } dsmc_cfg_t;

  typedef struct packed {
    logic [15:0] left_reload;
    logic [15:0] right_reload;
    logic        correcting;
  } dsmc_center_t;

  function automatic logic [3:0] seq_left(input logic [2:0] idx);
    logic [3:0] nib;
    case (idx)
      3'd0:    nib = 4'h9;
      3'd1:    nib = 4'h8;
      3'd2:    nib = 4'hA;
      3'd3:    nib = 4'h2;
      3'd4:    nib = 4'h6;
      3'd5:    nib = 4'h4;
      3'd6:    nib = 4'h5;
      default: nib = 4'h1;
    endcase
    return nib;
  endfunction

  function automatic logic [3:0] seq_right(input logic [2:0] idx);
    logic [3:0] nib;
    case (idx)
      3'd0:    nib = 4'h9;
      3'd1:    nib = 4'h1;
      3'd2:    nib = 4'h5;
      3'd3:    nib = 4'h4;
      3'd4:    nib = 4'h6;
      3'd5:    nib = 4'h2;
      3'd6:    nib = 4'hA;
      default: nib = 4'h8;
    endcase
    return nib;
  endfunction

endpackage

/* rtl/dsmc_cfg.sv */
`timescale 1ns / 1ps
// APB-style configuration register file for the move controller.
// Depends on dsmc_pkg.
module dsmc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dsmc_pkg::AddrW-1:0] paddr,
  input  logic [dsmc_pkg::DataW-1:0] pwdata,
  output logic [dsmc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output dsmc_pkg::dsmc_cfg_t       cfg_o
);
  import dsmc_pkg::*;

  dsmc_cfg_t  cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegStepsBlock:   cfg_d.steps_per_block        = pwdata[15:0];
        RegStepsQuarter: cfg_d.steps_per_quarter_turn = pwdata[14:0];
        RegBaseReload:   cfg_d.base_reload            = pwdata[15:0];
        RegWallLeft:     cfg_d.wall_limit_left        = pwdata[9:0];
        RegWallRight:    cfg_d.wall_limit_right       = pwdata[9:0];
        RegCenterLeft:   cfg_d.center_limit_left      = pwdata[9:0];
        RegCenterRight:  cfg_d.center_limit_right     = pwdata[9:0];
        RegFrontStop:    cfg_d.front_stop_limit       = pwdata[9:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegStepsBlock:   prdata = {16'd0, cfg_q.steps_per_block};
      RegStepsQuarter: prdata = {17'd0, cfg_q.steps_per_quarter_turn};
      RegBaseReload:   prdata = {16'd0, cfg_q.base_reload};
      RegWallLeft:     prdata = {22'd0, cfg_q.wall_limit_left};
      RegWallRight:    prdata = {22'd0, cfg_q.wall_limit_right};
      RegCenterLeft:   prdata = {22'd0, cfg_q.center_limit_left};
      RegCenterRight:  prdata = {22'd0, cfg_q.center_limit_right};
      RegFrontStop:    prdata = {22'd0, cfg_q.front_stop_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{base_reload: BaseReloadRst, front_stop_limit: FrontStopRst, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* rtl/dsmc_center.sv */
`timescale 1ns / 1ps
// Wall centering: nudges the two timer reloads around the base reload.
// Depends on dsmc_pkg.
module dsmc_center (
  input  dsmc_pkg::dsmc_cfg_t    cfg_i,
  input  logic [15:0]            left_reload_i,
  input  logic [15:0]            right_reload_i,
  input  logic [9:0]             left_reading_i,
  input  logic [9:0]             right_reading_i,
  output dsmc_pkg::dsmc_center_t res_o
);
  import dsmc_pkg::*;

  logic signed [18:0] base, hi, lo, step;
  logic signed [18:0] l1, r1, l2, r2;
  logic               near_r, near_l, wall_miss;

  function automatic logic [15:0] sat16(input logic signed [18:0] v);
    logic [15:0] res;
    if (v < 0) begin
      res = 16'd0;
    end else if (v > 19'sd65535) begin
      res = 16'hFFFF;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  always_comb begin
    base      = signed'({3'b000, cfg_i.base_reload});
    step      = signed'({3'b000, CenterStep});
    hi        = base + signed'({3'b000, CenterSpan});
    lo        = base - signed'({3'b000, CenterSpan});
    near_r    = right_reading_i < cfg_i.center_limit_right;
    near_l    = left_reading_i < cfg_i.center_limit_left;
    wall_miss = (right_reading_i < cfg_i.wall_limit_right) ||
                (left_reading_i < cfg_i.wall_limit_left);

    l1 = signed'({3'b000, left_reload_i});
    r1 = signed'({3'b000, right_reload_i});
    if (near_r) begin
      l1 = l1 + step;
      r1 = r1 - step;
      if (l1 > hi) l1 = hi;
      if (r1 < lo) r1 = lo;
    end
    l2 = l1;
    r2 = r1;
    if (near_l) begin
      l2 = l1 - step;
      r2 = r1 + step;
      if (r2 > hi) r2 = hi;
      if (l2 < lo) l2 = lo;
    end

    if (wall_miss || !(near_r || near_l)) begin
      res_o.left_reload  = cfg_i.base_reload;
      res_o.right_reload = cfg_i.base_reload;
      res_o.correcting   = 1'b0;
    end else begin
      res_o.left_reload  = sat16(l2);
      res_o.right_reload = sat16(r2);
      res_o.correcting   = 1'b1;
    end
  end

endmodule

/* rtl/dsmc_core.sv */
`timescale 1ns / 1ps
// Move state: active move, phases, step counters, reloads and coil nibbles.
// Depends on dsmc_pkg and dsmc_center.
module dsmc_core #(
  parameter int unsigned PHASE_COUNT     = dsmc_pkg::PhaseCountDef,
  parameter int unsigned STEP_COUNT_BITS = dsmc_pkg::StepCountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  dsmc_pkg::dsmc_in_t   req_i,
  input  dsmc_pkg::dsmc_cfg_t  cfg_i,
  output dsmc_pkg::dsmc_out_t  res_o
);
  import dsmc_pkg::*;

  localparam int unsigned PhaseW = $clog2(PHASE_COUNT);
  localparam int unsigned CntW   = STEP_COUNT_BITS;
  localparam int unsigned CmpW   = (CntW > 17) ? CntW : 17;
  localparam logic [PhaseW-1:0] PhaseLast = PhaseW'(PHASE_COUNT - 1);

  logic [2:0]        move_q, move_d;
  logic              busy_q, busy_d;
  logic [PhaseW-1:0] lph_q, lph_d, rph_q, rph_d;
  logic [CntW-1:0]   lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [15:0]       lrel_q, lrel_d, rrel_q, rrel_d;
  logic [3:0]        lnib_q, lnib_d, rnib_q, rnib_d;

  dsmc_center_t center;
  logic [16:0]  tgt;
  logic         stop, check_reach, reached, done, corr;
  logic         front_hit;

  function automatic logic [PhaseW-1:0] ph_fwd(input logic [PhaseW-1:0] p);
    return (p >= PhaseLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PhaseW-1:0] ph_back(input logic [PhaseW-1:0] p);
    return ((p == '0) || (p > PhaseLast)) ? PhaseLast : p - 1'b1;
  endfunction

  function automatic logic [CntW-1:0] cnt_inc(input logic [CntW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  dsmc_center u_center (
    .cfg_i           (cfg_i),
    .left_reload_i   (lrel_q),
    .right_reload_i  (rrel_q),
    .left_reading_i  (req_i.left_reading),
    .right_reading_i (req_i.right_reading),
    .res_o           (center)
  );

  assign front_hit = req_i.front_reading > cfg_i.front_stop_limit;

  always_comb begin
    case (move_d) inside
      MvFwd:                    tgt = {1'b0, cfg_i.steps_per_block};
      MvHalf, MvTurnL, MvTurnR: tgt = {2'b00, cfg_i.steps_per_block[15:1]};
      MvLeft, MvRight:          tgt = {2'b00, cfg_i.steps_per_quarter_turn};
      MvBack:                   tgt = {1'b0, cfg_i.steps_per_quarter_turn, 1'b0};
      default:                  tgt = {3'b000, cfg_i.steps_per_block[15:2]};
    endcase
  end

  always_comb begin
    case (move_d)
      MvTurnL: reached = CmpW'(rcnt_d) >= CmpW'(tgt);
      MvTurnR: reached = CmpW'(lcnt_d) >= CmpW'(tgt);
      default: reached = (CmpW'(lcnt_d) >= CmpW'(tgt)) && (CmpW'(rcnt_d) >= CmpW'(tgt));
    endcase
  end

  always_comb begin
    move_d      = move_q;
    busy_d      = busy_q;
    lph_d       = lph_q;
    rph_d       = rph_q;
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    lrel_d      = lrel_q;
    rrel_d      = rrel_q;
    lnib_d      = lnib_q;
    rnib_d      = rnib_q;
    stop        = 1'b0;
    check_reach = 1'b0;
    corr        = 1'b0;
    case (req_i.mode) inside
      ModeStart: begin
        move_d      = req_i.move;
        busy_d      = 1'b1;
        lcnt_d      = '0;
        rcnt_d      = '0;
        check_reach = 1'b1;
        stop        = (req_i.move == MvHalf) && front_hit;
        if (req_i.move == MvLeft || req_i.move == MvRight) begin
          lrel_d = ReloadTurn;
          rrel_d = ReloadTurn;
        end else if (req_i.move == MvBack) begin
          lrel_d = ReloadBack;
          rrel_d = ReloadBack;
        end
      end
      ModeTickL, ModeTickR: begin
        if (busy_q) begin
          if (req_i.mode == ModeTickL) begin
            case (move_q) inside
              MvLeft: begin
                lnib_d = seq_left(3'(lph_q));
                lph_d  = ph_back(lph_q);
              end
              MvRight, MvBack, MvFwd, MvHalf: begin
                lnib_d = seq_left(3'(lph_q));
                lph_d  = ph_fwd(lph_q);
              end
              default: lnib_d = lnib_q;
            endcase
          end else begin
            case (move_q) inside
              MvRight, MvBack: begin
                rnib_d = seq_right(3'(rph_q));
                rph_d  = ph_back(rph_q);
              end
              MvFwd, MvHalf, MvLeft: begin
                rnib_d = seq_right(3'(rph_q));
                rph_d  = ph_fwd(rph_q);
              end
              default: rnib_d = rnib_q;
            endcase
          end
          if (move_q == MvHalf && front_hit) begin
            stop = 1'b1;
          end else begin
            check_reach = 1'b1;
            if (move_q == MvHalf) begin
              lrel_d = center.left_reload;
              rrel_d = center.right_reload;
              corr   = center.correcting;
            end
            if (req_i.mode == ModeTickL) begin
              lcnt_d = cnt_inc(lcnt_q);
            end else begin
              rcnt_d = cnt_inc(rcnt_q);
            end
          end
        end
      end
      default: busy_d = busy_q;
    endcase
    done = stop || (check_reach && reached);
    if (done) busy_d = 1'b0;
  end

  assign res_o.left_coils         = lnib_d;
  assign res_o.right_coils        = rnib_d;
  assign res_o.left_timer_reload  = lrel_d;
  assign res_o.right_timer_reload = rrel_d;
  assign res_o.moving             = busy_d;
  assign res_o.move_done          = done;
  assign res_o.correcting         = corr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_q <= '0;
      busy_q <= 1'b0;
      lph_q  <= '0;
      rph_q  <= '0;
      lcnt_q <= '0;
      rcnt_q <= '0;
      lrel_q <= '0;
      rrel_q <= '0;
      lnib_q <= '0;
      rnib_q <= '0;
    end else if (fire_i) begin
      move_q <= move_d;
      busy_q <= busy_d;
      lph_q  <= lph_d;
      rph_q  <= rph_d;
      lcnt_q <= lcnt_d;
      rcnt_q <= rcnt_d;
      lrel_q <= lrel_d;
      rrel_q <= rrel_d;
      lnib_q <= lnib_d;
      rnib_q <= rnib_d;
    end
  end

endmodule

/* rtl/dual_stepper_move_controller.sv */
`timescale 1ns / 1ps
// Dual stepper move controller top: request register, move core, result register, config.
// An accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle without stalls; a stalled result lets in one more.
// Reset: asynchronous, active low; clears move state, empties both registers and loads
// the register defaults (base reload 65380, front stop limit 1023, all others 0).
// Depends on dsmc_pkg, dsmc_cfg, dsmc_core.
module dual_stepper_move_controller #(
  parameter int unsigned PHASE_COUNT     = dsmc_pkg::PhaseCountDef,
  parameter int unsigned STEP_COUNT_BITS = dsmc_pkg::StepCountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  dsmc_pkg::dsmc_in_t         in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output dsmc_pkg::dsmc_out_t        out_res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dsmc_pkg::AddrW-1:0] paddr,
  input  logic [dsmc_pkg::DataW-1:0] pwdata,
  output logic [dsmc_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import dsmc_pkg::*;

  dsmc_cfg_t cfg;
  dsmc_in_t  in_q;
  dsmc_out_t res, out_q;
  logic      in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic      accept, advance;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  dsmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsmc_core #(
    .PHASE_COUNT     (PHASE_COUNT),
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_req_i;
    if (advance) out_q <= res;
  end

endmodule

/* bench/dsmc_checker.sv */
`timescale 1ns / 1ps
// Checker for the dual stepper move controller: snoops the request, result and APB channels,
// predicts every result from its own copy of the move state and compares field by field.
// Depends on dsmc_pkg for the payload, config types and code names.
module dsmc_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  dsmc_pkg::dsmc_in_t         in_req_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  dsmc_pkg::dsmc_out_t        out_res_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dsmc_pkg::AddrW-1:0] paddr,
  input  logic [dsmc_pkg::DataW-1:0] pwdata,
  input  logic                       pready,
  output int                         fail_count_o,
  output int                         pending_o
);
  import dsmc_pkg::*;

  // coil nibbles, phase 0 in the low nibble
  localparam logic [31:0] LeftCoilSeq  = 32'h1546_2A89;
  localparam logic [31:0] RightCoilSeq = 32'h8A26_4519;

  dsmc_cfg_t   cfg;
  logic [2:0]  cur_move;
  logic        moving;
  logic [2:0]  lph, rph;
  logic [15:0] lsteps, rsteps;
  logic [15:0] lrel, rrel;
  logic [3:0]  lnib, rnib;
  dsmc_out_t   predicted_q[$];

  function automatic logic [16:0] move_target();
    case (cur_move) inside
      MvFwd:                    return {1'b0, cfg.steps_per_block};
      MvHalf, MvTurnL, MvTurnR: return {2'b0, cfg.steps_per_block[15:1]};
      MvLeft, MvRight:          return {2'b0, cfg.steps_per_quarter_turn};
      MvBack:                   return {1'b0, cfg.steps_per_quarter_turn, 1'b0};
      default:                  return {3'b0, cfg.steps_per_block[15:2]};
    endcase
  endfunction

  function automatic logic target_met();
    logic [16:0] tgt;
    tgt = move_target();
    if (cur_move == MvTurnL) return {1'b0, rsteps} >= tgt;
    if (cur_move == MvTurnR) return {1'b0, lsteps} >= tgt;
    return ({1'b0, lsteps} >= tgt) && ({1'b0, rsteps} >= tgt);
  endfunction

  function automatic logic [15:0] clip16(input int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  // wall centering, updates both reloads; returns 1 when a differential nudge was applied
  function automatic logic recenter(input logic [9:0] lr, input logic [9:0] rr);
    int base, l, r;
    logic nudged;
    base = int'(cfg.base_reload);
    l = int'(lrel);
    r = int'(rrel);
    nudged = 1'b0;
    if (rr < cfg.wall_limit_right || lr < cfg.wall_limit_left) begin
      lrel = cfg.base_reload;
      rrel = cfg.base_reload;
      return 1'b0;
    end
    if (rr < cfg.center_limit_right) begin
      l = l + 5;
      r = r - 5;
      if (l > base + 35) l = base + 35;
      if (r < base - 35) r = base - 35;
      nudged = 1'b1;
    end
    if (lr < cfg.center_limit_left) begin
      l = l - 5;
      r = r + 5;
      if (r > base + 35) r = base + 35;
      if (l < base - 35) l = base - 35;
      nudged = 1'b1;
    end
    if (!nudged) begin
      lrel = cfg.base_reload;
      rrel = cfg.base_reload;
      return 1'b0;
    end
    lrel = clip16(l);
    rrel = clip16(r);
    return 1'b1;
  endfunction

  task automatic predict_move(input dsmc_in_t req);
    dsmc_out_t res;
    logic done, corr, front_hit;
    done = 1'b0;
    corr = 1'b0;
    front_hit = req.front_reading > cfg.front_stop_limit;
    if (req.mode == ModeStart) begin
      cur_move = req.move;
      moving = 1'b1;
      lsteps = '0;
      rsteps = '0;
      if (req.move == MvLeft || req.move == MvRight) begin
        lrel = ReloadTurn;
        rrel = ReloadTurn;
      end else if (req.move == MvBack) begin
        lrel = ReloadBack;
        rrel = ReloadBack;
      end
      if ((req.move == MvHalf && front_hit) || target_met()) begin
        moving = 1'b0;
        done = 1'b1;
      end
    end else if ((req.mode == ModeTickL || req.mode == ModeTickR) && moving) begin
      if (req.mode == ModeTickL) begin
        if (cur_move == MvLeft) begin
          lnib = LeftCoilSeq[{lph, 2'b00} +: 4];
          lph = lph - 3'd1;
        end else if (cur_move == MvRight || cur_move == MvBack || cur_move == MvFwd ||
                     cur_move == MvHalf) begin
          lnib = LeftCoilSeq[{lph, 2'b00} +: 4];
          lph = lph + 3'd1;
        end
      end else begin
        if (cur_move == MvRight || cur_move == MvBack) begin
          rnib = RightCoilSeq[{rph, 2'b00} +: 4];
          rph = rph - 3'd1;
        end else if (cur_move == MvFwd || cur_move == MvHalf || cur_move == MvLeft) begin
          rnib = RightCoilSeq[{rph, 2'b00} +: 4];
          rph = rph + 3'd1;
        end
      end
      if (cur_move == MvHalf && front_hit) begin
        moving = 1'b0;
        done = 1'b1;
      end else begin
        if (cur_move == MvHalf) corr = recenter(req.left_reading, req.right_reading);
        if (req.mode == ModeTickL) begin
          if (lsteps != 16'hFFFF) lsteps = lsteps + 16'd1;
        end else begin
          if (rsteps != 16'hFFFF) rsteps = rsteps + 16'd1;
        end
        if (target_met()) begin
          moving = 1'b0;
          done = 1'b1;
        end
      end
    end
    res.left_coils         = lnib;
    res.right_coils        = rnib;
    res.left_timer_reload  = lrel;
    res.right_timer_reload = rrel;
    res.moving             = moving;
    res.move_done          = done;
    res.correcting         = corr;
    predicted_q.push_back(res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result(input dsmc_out_t got);
    dsmc_out_t want;
    if (predicted_q.size() == 0) begin
      $error("result with no request outstanding");
      fail_count_o++;
    end else begin
      want = predicted_q.pop_front();
      check_field("left_coils", int'(want.left_coils), int'(got.left_coils));
      check_field("right_coils", int'(want.right_coils), int'(got.right_coils));
      check_field("left_timer_reload", int'(want.left_timer_reload),
                  int'(got.left_timer_reload));
      check_field("right_timer_reload", int'(want.right_timer_reload),
                  int'(got.right_timer_reload));
      check_field("moving", int'(want.moving), int'(got.moving));
      check_field("move_done", int'(want.move_done), int'(got.move_done));
      check_field("correcting", int'(want.correcting), int'(got.correcting));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '0;
      cfg.base_reload = BaseReloadRst;
      cfg.front_stop_limit = FrontStopRst;
      cur_move = MvFwd;
      moving = 1'b0;
      lph = '0;
      rph = '0;
      lsteps = '0;
      rsteps = '0;
      lrel = '0;
      rrel = '0;
      lnib = '0;
      rnib = '0;
      predicted_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          RegStepsBlock:   cfg.steps_per_block = pwdata[15:0];
          RegStepsQuarter: cfg.steps_per_quarter_turn = pwdata[14:0];
          RegBaseReload:   cfg.base_reload = pwdata[15:0];
          RegWallLeft:     cfg.wall_limit_left = pwdata[9:0];
          RegWallRight:    cfg.wall_limit_right = pwdata[9:0];
          RegCenterLeft:   cfg.center_limit_left = pwdata[9:0];
          RegCenterRight:  cfg.center_limit_right = pwdata[9:0];
          default:         cfg.front_stop_limit = pwdata[9:0];
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_move(in_req_i);
      if (out_valid_i && !out_stall_i) check_result(out_res_i);
      pending_o = predicted_q.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the dual stepper move controller: clock, reset, APB setup and request
// stimulus (directed, random move sequences), plus the verdict.
// Depends on dsmc_pkg, dual_stepper_move_controller and dsmc_checker.
module tb;
  import dsmc_pkg::*;

  localparam logic [1:0] ModeSpare = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  dsmc_in_t             in_req_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  dsmc_out_t            out_res_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  int                   fail_count;
  int                   pending;
  logic                 quiet;
  dsmc_cfg_t            cfg_now;

  dual_stepper_move_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dsmc_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_req_i     (in_req_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_i    (out_res_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  // result side back-pressure
  initial begin : stall_gen
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        n = $urandom_range(0, 9);
        n = (n < 7) ? $urandom_range(1, 3) : (n < 9) ? $urandom_range(4, 10)
                                                     : $urandom_range(20, 40);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
        out_stall_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  function automatic dsmc_in_t mk(input logic [1:0] mode, input logic [2:0] mv,
                                  input logic [9:0] lr, input logic [9:0] rr,
                                  input logic [9:0] fr);
    dsmc_in_t r;
    r.mode = mode;
    r.move = mv;
    r.left_reading = lr;
    r.right_reading = rr;
    r.front_reading = fr;
    return r;
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_req(input dsmc_in_t req);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // wait out every outstanding result, then the pipeline latency
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] v, input int w);
    if ($urandom_range(0, 1) == 0) return v;
    return v | ($urandom() << w);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input dsmc_cfg_t c);
    cfg_now = c;
    reg_write(RegStepsBlock, with_junk(32'(c.steps_per_block), 16));
    reg_write(RegStepsQuarter, with_junk(32'(c.steps_per_quarter_turn), 15));
    reg_write(RegBaseReload, with_junk(32'(c.base_reload), 16));
    reg_write(RegWallLeft, with_junk(32'(c.wall_limit_left), 10));
    reg_write(RegWallRight, with_junk(32'(c.wall_limit_right), 10));
    reg_write(RegCenterLeft, with_junk(32'(c.center_limit_left), 10));
    reg_write(RegCenterRight, with_junk(32'(c.center_limit_right), 10));
    reg_write(RegFrontStop, with_junk(32'(c.front_stop_limit), 10));
  endtask

  function automatic dsmc_cfg_t rand_settings();
    dsmc_cfg_t c;
    c.steps_per_block = 16'($urandom_range(0, 40));
    c.steps_per_quarter_turn = 15'($urandom_range(0, 20));
    case ($urandom_range(0, 3))
      0: c.base_reload = 16'($urandom_range(0, 40));
      1: c.base_reload = 16'($urandom_range(65500, 65535));
      2: c.base_reload = 16'($urandom_range(65300, 65420));
      default: c.base_reload = 16'($urandom_range(0, 65535));
    endcase
    c.wall_limit_left = 10'($urandom_range(0, 300));
    c.wall_limit_right = 10'($urandom_range(0, 300));
    c.center_limit_left = 10'($urandom_range(100, 700));
    c.center_limit_right = 10'($urandom_range(100, 700));
    c.front_stop_limit = 10'($urandom_range(200, 1023));
    return c;
  endfunction

  function automatic logic [9:0] pick_reading(input logic [9:0] lim);
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'h3FF;
      2, 3: return lim + 10'($urandom_range(0, 6)) - 10'd3;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic int move_len(input logic [2:0] mv);
    case (mv) inside
      MvFwd:                    return int'(cfg_now.steps_per_block);
      MvHalf, MvTurnL, MvTurnR: return int'(cfg_now.steps_per_block) / 2;
      MvLeft, MvRight:          return int'(cfg_now.steps_per_quarter_turn);
      MvBack:                   return 2 * int'(cfg_now.steps_per_quarter_turn);
      default:                  return int'(cfg_now.steps_per_block) / 4;
    endcase
  endfunction

  function automatic dsmc_in_t rand_req(input logic [1:0] mode, input logic [2:0] mv);
    logic [9:0] lr, rr, fr;
    lr = pick_reading($urandom_range(0, 1) ? cfg_now.wall_limit_left
                                           : cfg_now.center_limit_left);
    rr = pick_reading($urandom_range(0, 1) ? cfg_now.wall_limit_right
                                           : cfg_now.center_limit_right);
    if (mv == MvHalf && $urandom_range(0, 11) != 0)
      fr = 10'($urandom_range(0, cfg_now.front_stop_limit));
    else
      fr = 10'($urandom_range(0, 1023));
    return mk(mode, mv, lr, rr, fr);
  endfunction

  // move sequences: a start, then mostly left/right ticks, with some noise
  task automatic run_moves(input int count);
    int sent, ticks, len, p;
    logic [2:0] mv;
    logic [1:0] mode;
    sent = 0;
    while (sent < count) begin
      quiet = ($urandom_range(0, 5) == 0);
      mv = 3'($urandom_range(0, 7));
      send_req(rand_req(ModeStart, mv));
      sent++;
      len = move_len(mv);
      if ($urandom_range(0, 7) == 0) ticks = $urandom_range(0, len);
      else ticks = 2 * len + $urandom_range(0, 4);
      if (ticks > 90) ticks = 90;
      for (int i = 0; i < ticks && sent < count; i++) begin
        p = $urandom_range(0, 39);
        if (p == 0) begin
          mv = 3'($urandom_range(0, 7));
          mode = ModeStart;
        end else if (p < 3) begin
          mode = ModeSpare;
        end else begin
          mode = p[0] ? ModeTickL : ModeTickR;
        end
        send_req(rand_req(mode, mv));
        sent++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin : stimulus
    dsmc_cfg_t c;
    rst_ni = 1'b0;
    quiet = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_now = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    c.steps_per_block = 16'd8;
    c.steps_per_quarter_turn = 15'd3;
    c.base_reload = BaseReloadRst;
    c.wall_limit_left = 10'd100;
    c.wall_limit_right = 10'd100;
    c.center_limit_left = 10'd300;
    c.center_limit_right = 10'd300;
    c.front_stop_limit = 10'd800;
    apply_settings(c);

    // ticks while idle and the unused mode
    send_req(mk(ModeTickL, MvFwd, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvTurnR, 10'h3FF, 10'h3FF, 10'h3FF));
    send_req(mk(ModeSpare, MvBack, 10'd512, 10'd512, 10'd512));
    // half move: front stop on start, then every centering branch, then front stop on a tick
    send_req(mk(ModeStart, MvHalf, 10'd500, 10'd500, 10'h3FF));
    send_req(mk(ModeStart, MvHalf, 10'd500, 10'd500, 10'd0));
    send_req(mk(ModeTickL, MvFwd, 10'd50, 10'd500, 10'd0));
    send_req(mk(ModeTickR, MvFwd, 10'd500, 10'd200, 10'd0));
    send_req(mk(ModeTickL, MvFwd, 10'd200, 10'd500, 10'd0));
    send_req(mk(ModeTickR, MvFwd, 10'd200, 10'd200, 10'd0));
    send_req(mk(ModeTickL, MvFwd, 10'd500, 10'd500, 10'd0));
    send_req(mk(ModeTickR, MvFwd, 10'd500, 10'd500, 10'd1000));
    send_req(mk(ModeStart, MvLeft, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickL, MvLeft, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvLeft, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeStart, MvBack, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickL, MvBack, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvBack, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeStart, MvQuarter, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickL, MvQuarter, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvQuarter, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeStart, MvTurnL, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvTurnL, 10'd0, 10'd0, 10'd0));
    // restart while busy
    send_req(mk(ModeStart, MvTurnR, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickL, MvTurnR, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeStart, MvRight, 10'd0, 10'd0, 10'd0));
    send_req(mk(ModeTickR, MvRight, 10'd0, 10'd0, 10'd0));
    settle();

    // all-zero registers: zero targets, front stop at 0, base at the bottom
    apply_settings('0);
    run_moves(60);
    settle();

    // all-ones registers
    c.steps_per_block = 16'hFFFF;
    c.steps_per_quarter_turn = 15'h7FFF;
    c.base_reload = 16'hFFFF;
    c.wall_limit_left = 10'h3FF;
    c.wall_limit_right = 10'h3FF;
    c.center_limit_left = 10'h3FF;
    c.center_limit_right = 10'h3FF;
    c.front_stop_limit = 10'h3FF;
    apply_settings(c);
    run_moves(40);
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      apply_settings(rand_settings());
      run_moves(60);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* dual_stepper_move_controller.f */
rtl/dsmc_pkg.sv
rtl/dsmc_cfg.sv
rtl/dsmc_center.sv
rtl/dsmc_core.sv
rtl/dual_stepper_move_controller.sv
bench/dsmc_checker.sv
bench/tb.sv
